// ===== design/itsu_pkg.sv =====
// Shared constants and types for the seconds/microseconds interval timer.
// No dependencies; imported by interval_timer_sec_usec.
package itsu_pkg;

  localparam int unsigned SecW  = 27;
  localparam int unsigned UsecW = 20;

  localparam logic [UsecW-1:0] UsecPerSec = UsecW'(1000000);
  localparam logic [UsecW-1:0] UsecMax    = UsecW'(999999);
  localparam logic [SecW-1:0]  MaxSec     = SecW'(100000000);
  localparam logic [UsecW-1:0] MinTickRst = UsecW'(10000);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INTERVAL_SEC  = 2'd0,
    CFG_INTERVAL_USEC = 2'd1,
    CFG_MIN_TICK_USEC = 2'd2
  } cfg_idx_e;

  // Request kind carried in tuser
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

  // Interval after normalising and saturating
  typedef struct packed {
    logic             zero;
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
  } ival_t;

endpackage

// ===== design/interval_timer_sec_usec.sv =====
// Countdown interval timer kept as seconds plus microseconds.
// Depends on itsu_pkg (constants, register indexes, interval type).
//
// Usage:
//   Slave stream (s_axis_*): one request per transfer. tuser selects the kind:
//   0 = tick (subtract elapsed_usec), 1 = load a new remaining value.
//   Master stream (m_axis_*): exactly one result per request, in order, giving
//   the remaining value after the request plus running / expired /
//   load_rejected flags.
//   Config channel (cfg_*): writes interval_sec (0), interval_usec (1) and
//   min_tick_usec (2); other indexes are dropped. Always ready; write only
//   while the timer has no request in flight. The interval is normalised and
//   saturated as it is written, so ticks see a ready-made reload value.
// Timing:
//   An input register, then the subtract/compare logic writes the timer state
//   and the result register together.
//   Throughput one request per cycle unless stalled (see Stall); the timer state is
//   updated with the result in the same cycle, so back-to-back ticks chain correctly.
// Reset: timer stopped (zero remaining), interval zero, resolution 10000 us,
//   both stages empty.
// Stall: while m_axis_tready is low a held result blocks the compute stage;
//   the input register still takes one request, then tready drops.
module interval_timer_sec_usec
  import itsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [19:0] elapsed_usec, [46:20] load_sec, [66:47] load_usec, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  // [0] func
  input  logic [0:0]  s_axis_tuser,
  // Master result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [26:0] value_sec, [46:27] value_usec, [47] running, [48] expired,
  // [49] load_rejected, [55:50] zero
  output logic [55:0] m_axis_tdata,
  // Config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [26:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SecW-1:0]  isec_q, isec_d;
  logic [UsecW-1:0] iusec_q, iusec_d;
  logic [UsecW-1:0] min_tick_q, min_tick_d;
  ival_t            ival_q, ival_d;
  logic             cfg_we;

  function automatic ival_t norm_ival(input logic [SecW-1:0] s, input logic [UsecW-1:0] u);
    ival_t          r;
    logic           carry;
    logic [SecW:0]  s_sum;
    logic [UsecW:0] u_sub;
    u_sub  = {1'b0, u} - {1'b0, UsecPerSec};
    carry  = ~u_sub[UsecW];
    s_sum  = {1'b0, s} + {{SecW{1'b0}}, carry};
    r.zero = (s == '0) && (u == '0);
    if (s_sum > {1'b0, MaxSec}) begin
      r.sec  = MaxSec;
      r.usec = UsecMax;
    end else begin
      r.sec  = s_sum[SecW-1:0];
      r.usec = carry ? u_sub[UsecW-1:0] : u;
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    isec_d     = isec_q;
    iusec_d    = iusec_q;
    min_tick_d = min_tick_q;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INTERVAL_SEC:  isec_d     = cfg_data_i;
        CFG_INTERVAL_USEC: iusec_d    = cfg_data_i[UsecW-1:0];
        CFG_MIN_TICK_USEC: min_tick_d = cfg_data_i[UsecW-1:0];
        default: ;
      endcase
    end
    ival_d = norm_ival(isec_d, iusec_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isec_q     <= '0;
      iusec_q    <= '0;
      min_tick_q <= MinTickRst;
      ival_q     <= '{zero: 1'b1, sec: '0, usec: '0};
    end else begin
      isec_q     <= isec_d;
      iusec_q    <= iusec_d;
      min_tick_q <= min_tick_d;
      ival_q     <= ival_d;
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: split elapsed into whole second + remainder, check and
  // round the load value, then register.
  // ---------------------------------------------------------------------
  logic             in_valid_q;
  logic             in_func_q;
  logic             in_esec_q;
  logic [UsecW-1:0] in_eusec_q;
  logic             in_lbad_q;
  logic [SecW-1:0]  in_lsec_q;
  logic [UsecW-1:0] in_lusec_q;

  logic [UsecW-1:0] elapsed, lusec_raw, tick_res, lusec_rnd;
  logic [SecW-1:0]  lsec_raw;
  logic [UsecW:0]   e_sub;
  logic             e_sec, l_bad;
  logic             adv, s_fire;

  assign elapsed   = s_axis_tdata[19:0];
  assign lsec_raw  = s_axis_tdata[46:20];
  assign lusec_raw = s_axis_tdata[66:47];

  always_comb begin
    e_sub     = {1'b0, elapsed} - {1'b0, UsecPerSec};
    e_sec     = ~e_sub[UsecW];
    l_bad     = (lsec_raw > MaxSec) || (lusec_raw >= UsecPerSec);
    tick_res  = (min_tick_q > UsecMax) ? UsecMax : min_tick_q;
    lusec_rnd = lusec_raw;
    // Nonzero value below one tick rounds up to one tick
    if (lsec_raw == '0 && lusec_raw != '0 && lusec_raw < tick_res) begin
      lusec_rnd = tick_res;
    end
  end

  assign adv           = in_valid_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_func_q  <= s_axis_tuser[0];
      in_esec_q  <= e_sec;
      in_eusec_q <= e_sec ? e_sub[UsecW-1:0] : elapsed;
      in_lbad_q  <= l_bad;
      in_lsec_q  <= lsec_raw;
      in_lusec_q <= lusec_rnd;
    end
  end

  // ---------------------------------------------------------------------
  // Compute stage: timer state update and result
  // ---------------------------------------------------------------------
  logic [SecW-1:0]  rem_sec_q, rem_sec_d;
  logic [UsecW-1:0] rem_usec_q, rem_usec_d;
  logic             expired_d, rejected_d;

  logic [UsecW:0]   du_raw, ru_raw;
  logic [UsecW-1:0] d_usec, o_usec, r_usec;
  logic [SecW:0]    d_sec, r_sec;
  logic             d_b, r_b, o_sec, cur_nz, hit_zero, reload_pos;

  always_comb begin
    // remaining - elapsed, in sec/usec form with borrow
    du_raw   = {1'b0, rem_usec_q} - {1'b0, in_eusec_q};
    d_b      = du_raw[UsecW];
    d_usec   = d_b ? (du_raw[UsecW-1:0] + UsecPerSec) : du_raw[UsecW-1:0];
    d_sec    = {1'b0, rem_sec_q} - {{SecW{1'b0}}, in_esec_q} - {{SecW{1'b0}}, d_b};
    cur_nz   = (rem_sec_q != '0) || (rem_usec_q != '0);
    hit_zero = d_sec[SecW] || (d_sec == '0 && d_usec == '0);

    // Overshoot past zero: below two seconds, so one second bit
    if (d_usec == '0) begin
      o_sec  = (d_sec == {(SecW+1){1'b1}});
      o_usec = '0;
    end else begin
      o_sec  = (d_sec == {{SecW{1'b1}}, 1'b0});
      o_usec = UsecPerSec - d_usec;
    end

    // Reload = interval - overshoot, clamped to one microsecond
    ru_raw     = {1'b0, ival_q.usec} - {1'b0, o_usec};
    r_b        = ru_raw[UsecW];
    r_usec     = r_b ? (ru_raw[UsecW-1:0] + UsecPerSec) : ru_raw[UsecW-1:0];
    r_sec      = {1'b0, ival_q.sec} - {{SecW{1'b0}}, o_sec} - {{SecW{1'b0}}, r_b};
    reload_pos = ~r_sec[SecW] && (r_sec != '0 || r_usec != '0);

    rem_sec_d  = rem_sec_q;
    rem_usec_d = rem_usec_q;
    expired_d  = 1'b0;
    rejected_d = 1'b0;
    if (func_e'(in_func_q) == FUNC_LOAD) begin
      if (in_lbad_q) begin
        rejected_d = 1'b1;
      end else begin
        rem_sec_d  = in_lsec_q;
        rem_usec_d = in_lusec_q;
      end
    end else if (cur_nz) begin
      if (!hit_zero) begin
        rem_sec_d  = d_sec[SecW-1:0];
        rem_usec_d = d_usec;
      end else begin
        expired_d = 1'b1;
        if (ival_q.zero) begin
          rem_sec_d  = '0;
          rem_usec_d = '0;
        end else if (reload_pos) begin
          rem_sec_d  = r_sec[SecW-1:0];
          rem_usec_d = r_usec;
        end else begin
          rem_sec_d  = '0;
          rem_usec_d = UsecW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_sec_q  <= '0;
      rem_usec_q <= '0;
    end else if (adv) begin
      rem_sec_q  <= rem_sec_d;
      rem_usec_q <= rem_usec_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic             out_valid_q;
  logic [SecW-1:0]  out_sec_q;
  logic [UsecW-1:0] out_usec_q;
  logic             out_run_q, out_exp_q, out_rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sec_q  <= rem_sec_d;
      out_usec_q <= rem_usec_d;
      out_run_q  <= (rem_sec_d != '0) || (rem_usec_d != '0);
      out_exp_q  <= expired_d;
      out_rej_q  <= rejected_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_rej_q, out_exp_q, out_run_q, out_usec_q, out_sec_q};

endmodule

// ===== verif/itsu_checker.sv =====
`timescale 1ns / 1ps
// Result checker for interval_timer_sec_usec. It mirrors the timer state and
// its registers, predicts one result per request and compares in order.
// Depends on itsu_pkg for widths, constants, register indexes and request kinds.
module itsu_checker
  import itsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [71:0] s_data_i,
  input  logic [0:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [55:0] m_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [26:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          expiries_o,
  output int          rejects_o
);

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
    logic             running;
    logic             expired;
    logic             rejected;
  } timer_result_t;

  localparam longint unsigned UsecPerSecL = 64'(UsecPerSec);
  localparam longint unsigned MaxTotal    = 64'(MaxSec) * UsecPerSecL + 64'(UsecMax);

  logic [SecW-1:0]  rem_sec;
  logic [UsecW-1:0] rem_usec;
  logic [SecW-1:0]  ival_sec;
  logic [UsecW-1:0] ival_usec;
  logic [UsecW-1:0] res_usec;

  timer_result_t expected_results[$];
  timer_result_t predicted;
  int            mismatch_count = 0;
  int            expiry_count   = 0;
  int            reject_count   = 0;

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatch_count++;
    $display("[%0t] %s mismatch: got %0d, want %0d", $time, field, got, want);
  endtask

  // One request applied to the mirrored timer; returns the result it gives.
  function automatic timer_result_t advance_timer(func_e kind, logic [UsecW-1:0] elapsed,
                                                  logic [SecW-1:0] lsec,
                                                  logic [UsecW-1:0] lusec);
    timer_result_t    r;
    logic [UsecW-1:0] tick;
    longint unsigned  now_total;
    longint unsigned  over;
    longint unsigned  reload;
    longint unsigned  next_total;
    r = '0;
    if (kind == FUNC_LOAD) begin
      if (lsec > MaxSec || lusec >= UsecPerSec) begin
        r.rejected = 1'b1;
      end else begin
        tick = (res_usec > UsecMax) ? UsecMax : res_usec;
        if (lsec == '0 && lusec != '0 && lusec < tick) lusec = tick;
        rem_sec  = lsec;
        rem_usec = lusec;
      end
    end else begin
      now_total = 64'(rem_sec) * UsecPerSecL + 64'(rem_usec);
      if (now_total != 0) begin
        if (64'(elapsed) < now_total) begin
          next_total = now_total - 64'(elapsed);
        end else begin
          // expiry: reload from the interval less the overshoot
          over      = 64'(elapsed) - now_total;
          reload    = 64'(ival_sec) * UsecPerSecL + 64'(ival_usec);
          r.expired = 1'b1;
          if (reload == 0) begin
            next_total = 0;
          end else begin
            if (reload > MaxTotal) reload = MaxTotal;
            next_total = (reload > over) ? reload - over : 64'd1;
          end
        end
        rem_sec  = SecW'(next_total / UsecPerSecL);
        rem_usec = UsecW'(next_total % UsecPerSecL);
      end
    end
    r.sec     = rem_sec;
    r.usec    = rem_usec;
    r.running = (rem_sec != '0) || (rem_usec != '0);
    return r;
  endfunction

  task automatic check_result(logic [55:0] word);
    timer_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unrequested result", word, 0);
    end else begin
      want = expected_results.pop_front();
      if (word[26:0] != want.sec) report_mismatch("value_sec", word[26:0], want.sec);
      if (word[46:27] != want.usec) report_mismatch("value_usec", word[46:27], want.usec);
      if (word[47] != want.running) report_mismatch("running", word[47], want.running);
      if (word[48] != want.expired) report_mismatch("expired", word[48], want.expired);
      if (word[49] != want.rejected) report_mismatch("load_rejected", word[49], want.rejected);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_sec   = '0;
      rem_usec  = '0;
      ival_sec  = '0;
      ival_usec = '0;
      res_usec  = MinTickRst;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) check_result(m_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INTERVAL_SEC:  ival_sec  = cfg_data_i;
          CFG_INTERVAL_USEC: ival_usec = cfg_data_i[UsecW-1:0];
          CFG_MIN_TICK_USEC: res_usec  = cfg_data_i[UsecW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        predicted = advance_timer(func_e'(s_user_i[0]), s_data_i[19:0], s_data_i[46:20],
                                  s_data_i[66:47]);
        if (predicted.expired) expiry_count++;
        if (predicted.rejected) reject_count++;
        expected_results.push_back(predicted);
      end
      pending_o <= expected_results.size();
    end
    errors_o   <= mismatch_count;
    expiries_o <= expiry_count;
    rejects_o  <= reject_count;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench for interval_timer_sec_usec: clock, reset, request and
// register stimulus, result-side back-pressure and the verdict.
// Depends on itsu_pkg, the timer RTL and itsu_checker (itsu_checker.sv).
module tb;
  import itsu_pkg::*;

  // Longest run of cycles with no handshake on any channel before giving up.
  // The worst honest case is the deliberate hold-off below plus a few gaps.
  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 300;
  localparam int PhaseItems    = 240;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [26:0] cfg_data_i    = '0;

  int check_errors;
  int check_pending;
  int check_expiries;
  int check_rejects;

  int items_sent      = 0;
  int tick_count      = 0;
  int load_count      = 0;
  int settings_count  = 0;
  int burst_left      = 0;
  int holdoffs_asked  = 0;
  int holdoffs_served = 0;
  int quiet_cycles    = 0;
  bit sender_gaps     = 1'b1;
  bit sink_stalls     = 1'b1;

  always #6 clk_i = ~clk_i;

  interval_timer_sec_usec DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  itsu_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (check_errors),
    .pending_o   (check_pending),
    .expiries_o  (check_expiries),
    .rejects_o   (check_rejects)
  );

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offers one request and returns at the edge where it is taken. tvalid is
  // left high so the next request can follow back to back; the sender only
  // drops it when a burst ends and a gap is drawn.
  task automatic offer(func_e kind, logic [UsecW-1:0] elapsed, logic [SecW-1:0] lsec,
                       logic [UsecW-1:0] lusec);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, lusec, lsec, elapsed};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (kind == FUNC_TICK) tick_count++;
    else load_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // mostly short gaps so they land on every pipeline stage, now and
      // then a long one that lets the block drain completely
      gap = !sender_gaps ? 0 : ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                            : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Load fields are junk on ticks and elapsed is junk on loads: the block
  // must ignore the field that does not belong to the request kind.
  task automatic do_tick(logic [UsecW-1:0] elapsed);
    offer(FUNC_TICK, elapsed, SecW'($urandom), UsecW'($urandom));
  endtask

  task automatic do_load(logic [SecW-1:0] lsec, logic [UsecW-1:0] lusec);
    offer(FUNC_LOAD, UsecW'($urandom), lsec, lusec);
  endtask

  // Elapsed time for one tick: zero, a second or more (subtracted in full),
  // small steps near the resolution, or anything below a second.
  function automatic logic [UsecW-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return UsecW'($urandom_range(1000000, 1048575));
      2, 3:    return UsecW'($urandom_range(1, 50000));
      default: return UsecW'($urandom_range(0, 999999));
    endcase
  endfunction

  // One well-formed run: a load followed by a string of ticks. Most loads are
  // short so the ticks reach expiry; the quantised runs make the count land
  // exactly on zero. A tenth of the runs are plain noise.
  task automatic run_sequence();
    int unsigned n_ticks;
    int unsigned quantum;
    n_ticks = $urandom_range(1, 12);
    quantum = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: do_load(SecW'($urandom_range(0, 2)), UsecW'($urandom_range(0, 999999)));
      3:       do_load('0, UsecW'($urandom_range(1, 20000)));   // around the resolution
      4, 5: begin
        case ($urandom_range(0, 2))
          0:       quantum = 1000;
          1:       quantum = 10000;
          default: quantum = 125000;
        endcase
        do_load('0, UsecW'(quantum * $urandom_range(1, 999999 / quantum)));
      end
      6:       do_load(SecW'($urandom_range(0, MaxSec)), UsecW'($urandom_range(0, 999999)));
      7: begin
        // out of range on one field or the other
        if ($urandom_range(0, 1) != 0)
          do_load(SecW'($urandom_range(MaxSec + 1, 134217727)),
                  UsecW'($urandom_range(0, 1048575)));
        else
          do_load(SecW'($urandom_range(0, MaxSec)), UsecW'($urandom_range(1000000, 1048575)));
      end
      8:       do_load('0, '0);                                  // stop, then idle ticks
      default: begin
        repeat (n_ticks)
          offer(func_e'($urandom_range(0, 1)), UsecW'($urandom), SecW'($urandom),
                UsecW'($urandom));
        n_ticks = 0;
      end
    endcase
    repeat (n_ticks)
      do_tick(quantum != 0 ? UsecW'(quantum * $urandom_range(1, 2)) : pick_elapsed());
  endtask

  // Stop offering and wait until every request has produced its result. The
  // pending count is registered in the checker, so it lags the checker's queue.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (check_pending != 0);
  endtask

  // ---------------------------------------------------------------------
  // Register writes, only ever issued with nothing in flight
  // ---------------------------------------------------------------------

  task automatic write_reg(cfg_idx_e idx, logic [26:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_timer(logic [26:0] isec, logic [26:0] iusec, logic [26:0] tick);
    write_reg(CFG_INTERVAL_SEC, isec);
    write_reg(CFG_INTERVAL_USEC, iusec);
    write_reg(CFG_MIN_TICK_USEC, tick);
    cfg_valid_i <= 1'b0;
    settings_count++;
  endtask

  // One random phase under one register setting. With hold_off set the
  // result side is frozen while the sender keeps pushing requests back to back.
  task automatic run_phase(logic [26:0] isec, logic [26:0] iusec, logic [26:0] tick,
                           bit gaps, bit stalls, bit hold_off);
    int start;
    drain();
    program_timer(isec, iusec, tick);
    sink_stalls = stalls;
    start       = items_sent;
    if (hold_off) begin
      sender_gaps = 1'b0;
      holdoffs_asked++;
      while (items_sent - start < 40) run_sequence();
    end
    sender_gaps = gaps;
    while (items_sent - start < PhaseItems) run_sequence();
  endtask

  // ---------------------------------------------------------------------
  // Result side: runs of ready and stall of random length, or a long
  // hold-off when the stimulus asks for one.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    logic level;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holdoffs_served != holdoffs_asked) begin
        holdoffs_served++;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (sink_stalls) begin
        level = ($urandom_range(0, 2) != 0);
        m_axis_tready <= level;
        repeat ($urandom_range(1, level ? 8 : 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, check_pending);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------
  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset registers: no interval, 10 ms resolution.
    do_tick(UsecMax);                       // tick while stopped
    do_load('0, '0);                        // zero load
    do_load(MaxSec, UsecMax);               // largest legal value
    do_tick('0);
    do_load(SecW'(MaxSec + 1), '0);         // seconds out of range
    do_load('0, UsecPerSec);                // microseconds out of range
    do_load('1, '1);                        // both fields at their maximum
    do_load('0, UsecW'(1));                 // below resolution, rounded up
    do_tick(UsecW'(10000));                 // exact expiry, no interval: stops
    do_load('0, UsecW'(9999));
    do_tick('1);                            // more than a second, expires
    do_load('0, UsecW'(10000));             // exactly one tick, kept
    do_tick(UsecW'(4000));
    do_tick(UsecW'(6000));

    // Short interval, resolution zero: no rounding; overshoot past the
    // interval clamps the reload to one microsecond.
    drain();
    program_timer(27'd0, 27'd300000, 27'd0);
    do_load('0, UsecW'(1));
    do_tick(UsecW'(1));
    do_tick('1);
    do_tick('0);
    do_tick(UsecW'(1));

    // All register bits set: interval saturates, resolution treated as
    // just under a second.
    drain();
    program_timer('1, '1, '1);
    do_load('0, UsecW'(5));
    do_tick(UsecMax);
    do_tick('1);

    // Random phases, extremes of every register among them.
    run_phase(27'd0, 27'd250000, 27'd10000, 1'b1, 1'b1, 1'b0);
    run_phase(27'd0, 27'd1, 27'd1, 1'b0, 1'b0, 1'b0);
    run_phase(27'd1, 27'd500000, 27'd0, 1'b1, 1'b1, 1'b1);
    run_phase(MaxSec, UsecMax, UsecMax, 1'b1, 1'b1, 1'b0);
    run_phase('1, '1, '1, 1'b1, 1'b0, 1'b0);
    run_phase(27'd3, 27'd0, 27'd999999, 1'b0, 1'b1, 1'b0);
    repeat (2)
      run_phase(27'($urandom_range(0, 8)), 27'($urandom), 27'($urandom), 1'b1, 1'b1, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests (%0d ticks, %0d loads) under %0d register settings,",
             items_sent, tick_count, load_count, settings_count);
    $display("with %0d expiries and %0d rejected loads among them.",
             check_expiries, check_rejects);
    if (check_errors == 0 && check_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
